>>> rtl/playfair_encrypt_engine_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Playfair encryption engine
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_ENCRYPT_ENGINE_TOP_ASSERT_SVH
`define PLAYFAIR_ENCRYPT_ENGINE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PFE_ASSERT_IMPL(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("%m: same-cycle implication failed");
`define PFE_ASSERT_NEXT(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");
`else
`define PFE_ASSERT_IMPL(name, clock, resetn, ante, cons)
`define PFE_ASSERT_NEXT(name, clock, resetn, ante, cons)
`endif

`endif

>>> rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared constants, opcodes, helper functions and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int SQUARE_SIDE   = 5;
    localparam int LETTER_W      = 5;
    localparam int COORD_W       = 3;

    localparam logic [LETTER_W-1:0] ALPHABET_COUNT = LETTER_W'(ALPHABET_SIZE);
    localparam logic [LETTER_W-1:0] LAST_LETTER    = LETTER_W'(ALPHABET_SIZE - 1);
    localparam logic [LETTER_W-1:0] CELL_COUNT     = LETTER_W'(SQUARE_SIDE * SQUARE_SIDE);
    localparam logic [COORD_W-1:0]  SIDE_LAST      = COORD_W'(SQUARE_SIDE - 1);
    localparam logic [LETTER_W-1:0] LETTER_I       = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J       = 5'd9;

    localparam logic [2:0] OP_BEGIN       = 3'd0;
    localparam logic [2:0] OP_KEY_LETTER  = 3'd1;
    localparam logic [2:0] OP_KEY_DONE    = 3'd2;
    localparam logic [2:0] OP_TEXT_LETTER = 3'd3;
    localparam logic [2:0] OP_TEXT_END    = 3'd4;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } pfe_pos_t;

    typedef struct packed {
        logic latch;
        logic clear;
        logic place;
        logic walk_start;
        logic walk_step;
        logic set_pending;
        logic load_text;
        logic load_filler;
        logic drop_pending;
        logic read_pos;
        logic read_cell;
        logic push;
    } pfe_cmd_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic       letter_ok;
        logic       pend_valid;
        logic       letter_eq_pend;
        logic       walk_last;
        logic       ob_busy;
    } pfe_stat_t;

    // Next filler candidate: steps through A..Z and never lands on J.
    function automatic logic [LETTER_W-1:0] advance_counter(input logic [LETTER_W-1:0] e);
        logic [LETTER_W-1:0] n;
        n = (e == LAST_LETTER) ? '0 : e + 1'b1;
        if (n == LETTER_J)
            n = n + 1'b1;
        return n;
    endfunction

    function automatic logic [COORD_W-1:0] coord_inc(input logic [COORD_W-1:0] v);
        return (v == SIDE_LAST) ? '0 : v + 1'b1;
    endfunction

    function automatic logic [LETTER_W-1:0] cell_index(input logic [COORD_W-1:0] row,
                                                       input logic [COORD_W-1:0] col);
        return LETTER_W'({2'b00, row} * LETTER_W'(SQUARE_SIDE)) + {2'b00, col};
    endfunction

endpackage

`default_nettype wire

>>> rtl/pfe_ctrl.sv
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer: decodes each accepted word and steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire pfe_pkg::pfe_stat_t stat,
    output pfe_pkg::pfe_cmd_t     cmd
);
    import pfe_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_WALK   = 3'd2;
    localparam logic [2:0] ST_POS    = 3'd3;
    localparam logic [2:0] ST_CELL   = 3'd4;
    localparam logic [2:0] ST_PUSH   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_IDLE;
                unique case (stat.opcode)
                    OP_BEGIN:      cmd.clear = 1'b1;
                    OP_KEY_LETTER: cmd.place = 1'b1;
                    OP_KEY_DONE:
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = ST_WALK;
                    end
                    OP_TEXT_LETTER:
                    begin
                        if (stat.letter_ok)
                        begin
                            if (!stat.pend_valid)
                            begin
                                cmd.set_pending = 1'b1;
                            end
                            else if (!stat.letter_eq_pend)
                            begin
                                cmd.load_text    = 1'b1;
                                cmd.drop_pending = 1'b1;
                                state_next       = ST_POS;
                            end
                            else
                            begin
                                // Doubled letter: the first takes a filler, the
                                // second stays pending.
                                cmd.load_filler = 1'b1;
                                state_next      = ST_POS;
                            end
                        end
                    end
                    OP_TEXT_END:
                    begin
                        if (stat.pend_valid)
                        begin
                            cmd.load_filler  = 1'b1;
                            cmd.drop_pending = 1'b1;
                            state_next       = ST_POS;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_WALK:
            begin
                cmd.place     = 1'b1;
                cmd.walk_step = 1'b1;
                if (stat.walk_last)
                    state_next = ST_IDLE;
            end
            ST_POS:
            begin
                cmd.read_pos = 1'b1;
                state_next   = ST_CELL;
            end
            ST_CELL:
            begin
                cmd.read_cell = 1'b1;
                state_next    = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!stat.ob_busy)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

>>> rtl/pfe_dp.sv
// ----------------------------------------------------------------------------
// pfe_dp
// Datapath: key square, letter positions, pairing state and output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [2:0]         in_opcode,
    input  wire logic [4:0]         in_letter,
    input  wire pfe_pkg::pfe_cmd_t  cmd,
    output pfe_pkg::pfe_stat_t      stat,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [4:0]              out_letter,
    output logic                    out_last
);
    import pfe_pkg::*;

    // Square and letter positions are only read for letters placed since begin.
    logic [LETTER_W-1:0] square_mem [SQUARE_SIDE*SQUARE_SIDE];
    pfe_pos_t            pos_mem    [ALPHABET_SIZE];

    logic [ALPHABET_SIZE-1:0] used_reg;
    logic [LETTER_W-1:0]      fill_reg;
    logic [COORD_W-1:0]       fill_row_reg;
    logic [COORD_W-1:0]       fill_col_reg;
    logic [LETTER_W-1:0]      ctr_reg;
    logic [LETTER_W-1:0]      ctr_next;
    logic [LETTER_W-1:0]      pend_reg;
    logic                     pend_valid_reg;
    logic [2:0]               op_reg;
    logic [LETTER_W-1:0]      letter_reg;
    logic [LETTER_W-1:0]      a_reg;
    logic [LETTER_W-1:0]      b_reg;
    pfe_pos_t                 pos_a_reg;
    pfe_pos_t                 pos_b_reg;
    logic [LETTER_W-1:0]      x_reg;
    logic [LETTER_W-1:0]      y_reg;
    logic                     ob_valid_reg;
    logic                     ob_phase_reg;
    logic [LETTER_W-1:0]      ob_x_reg;
    logic [LETTER_W-1:0]      ob_y_reg;

    logic                letter_ok;
    logic                place_ok;
    logic [LETTER_W-1:0] filler;
    logic [LETTER_W-1:0] cand0;
    logic [LETTER_W-1:0] cand1;
    logic [LETTER_W-1:0] idx_x;
    logic [LETTER_W-1:0] idx_y;

    assign letter_ok = (letter_reg < ALPHABET_COUNT);
    assign place_ok  = letter_ok && !used_reg[letter_reg] && (fill_reg < CELL_COUNT);

    // Filler skips the pending letter by taking one more counter step.
    assign cand0 = ctr_reg;
    assign cand1 = advance_counter(ctr_reg);
    always_comb
    begin
        if (cand0 == pend_reg)
        begin
            filler   = cand1;
            ctr_next = advance_counter(cand1);
        end
        else
        begin
            filler   = cand0;
            ctr_next = cand1;
        end
    end

    // Same row: shift right. Same column: shift down. Otherwise swap columns.
    always_comb
    begin
        if (pos_a_reg.row == pos_b_reg.row)
        begin
            idx_x = cell_index(pos_a_reg.row, coord_inc(pos_a_reg.col));
            idx_y = cell_index(pos_b_reg.row, coord_inc(pos_b_reg.col));
        end
        else if (pos_a_reg.col == pos_b_reg.col)
        begin
            idx_x = cell_index(coord_inc(pos_a_reg.row), pos_a_reg.col);
            idx_y = cell_index(coord_inc(pos_b_reg.row), pos_b_reg.col);
        end
        else
        begin
            idx_x = cell_index(pos_a_reg.row, pos_b_reg.col);
            idx_y = cell_index(pos_b_reg.row, pos_a_reg.col);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.place && place_ok)
        begin
            square_mem[fill_reg] <= letter_reg;
            pos_mem[letter_reg]  <= '{row: fill_row_reg, col: fill_col_reg};
        end
        if (cmd.read_pos)
        begin
            pos_a_reg <= pos_mem[a_reg];
            pos_b_reg <= pos_mem[b_reg];
        end
        if (cmd.read_cell)
        begin
            x_reg <= square_mem[idx_x];
            y_reg <= square_mem[idx_y];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg     <= in_opcode;
            letter_reg <= (in_letter == LETTER_J) ? LETTER_I : in_letter;
        end
        else if (cmd.walk_start)
        begin
            letter_reg <= '0;
        end
        else if (cmd.walk_step)
        begin
            letter_reg <= letter_reg + 1'b1;
        end
        if (cmd.load_text)
        begin
            a_reg <= pend_reg;
            b_reg <= letter_reg;
        end
        else if (cmd.load_filler)
        begin
            a_reg <= pend_reg;
            b_reg <= filler;
        end
        if (cmd.push)
        begin
            ob_x_reg <= x_reg;
            ob_y_reg <= y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            fill_reg       <= '0;
            fill_row_reg   <= '0;
            fill_col_reg   <= '0;
            ctr_reg        <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            used_reg       <= '0;
            fill_reg       <= '0;
            fill_row_reg   <= '0;
            fill_col_reg   <= '0;
            ctr_reg        <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.place && place_ok)
            begin
                used_reg[letter_reg] <= 1'b1;
                if (letter_reg == LETTER_I)
                    used_reg[LETTER_J] <= 1'b1;
                fill_reg <= fill_reg + 1'b1;
                if (fill_col_reg == SIDE_LAST)
                begin
                    fill_col_reg <= '0;
                    fill_row_reg <= fill_row_reg + 1'b1;
                end
                else
                begin
                    fill_col_reg <= fill_col_reg + 1'b1;
                end
            end
            if (cmd.load_filler)
                ctr_reg <= ctr_next;
            if (cmd.set_pending)
            begin
                pend_reg       <= letter_reg;
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.drop_pending)
            begin
                pend_reg       <= '0;
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_valid_reg <= 1'b0;
            ob_phase_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            ob_valid_reg <= 1'b1;
            ob_phase_reg <= 1'b0;
        end
        else if (ob_valid_reg && out_ready)
        begin
            ob_phase_reg <= !ob_phase_reg;
            if (ob_phase_reg)
                ob_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = ob_valid_reg;
    assign out_letter = ob_phase_reg ? ob_y_reg : ob_x_reg;
    assign out_last   = ob_phase_reg;

    assign stat.opcode         = op_reg;
    assign stat.letter_ok      = letter_ok;
    assign stat.pend_valid     = pend_valid_reg;
    assign stat.letter_eq_pend = (letter_reg == pend_reg);
    assign stat.walk_last      = (letter_reg == LAST_LETTER);
    assign stat.ob_busy        = ob_valid_reg;

endmodule

`default_nettype wire

>>> rtl/playfair_encrypt_engine_top.sv
// ----------------------------------------------------------------------------
// playfair_encrypt_engine_top
// Playfair encryptor over letter codes with a streaming command input.
// ----------------------------------------------------------------------------
// Usage: each input word carries an opcode in s_tuser (begin, key letter,
// key done, text letter, text end) and a letter code in s_tdata. A begin word
// clears the key square and the pairing state. Key letters fill the square in
// first-seen order; key done completes it alphabetically. Text letters are
// paired, and each enciphered pair leaves on the output as two words, the
// second marked by m_tlast.
// Sequencing: the input is taken in an idle cycle and decoded in the next;
// begin, key letter and unpaired text words end there. Key done walks the
// alphabet through the single square write port, one letter per cycle. A
// word that completes a pair passes through decode, a position memory read,
// a square memory read and the hand-off to the output buffer, which waits
// while the buffer still holds the previous pair for the receiver.
// Reset returns the block to idle with an empty square, no pending letter and
// the filler counter at A. When the receiver stalls, the two-word output
// buffer holds the pair; further words are still accepted until another pair
// needs the buffer, at which point s_tready stays low until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

`include "playfair_encrypt_engine_top_assert.svh"

module playfair_encrypt_engine_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [4:0] letter, [7:5] zero
    input  wire logic [2:0] s_tuser,   // [2:0] opcode
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [4:0] cipher_letter, [7:5] zero
    output logic            m_tlast    // last_of_run
);
    import pfe_pkg::*;

    pfe_cmd_t            cmd;
    pfe_stat_t           stat;
    logic [LETTER_W-1:0] cipher_letter;

    // The controller sequences every word; all data storage sits in the datapath.
    pfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfe_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_opcode  (s_tuser),
        .in_letter  (s_tdata[4:0]),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_letter (cipher_letter),
        .out_last   (m_tlast)
    );

    assign m_tdata = {3'b000, cipher_letter};

    // Every accepted word needs a decode cycle before the next is taken.
    `PFE_ASSERT_NEXT(a_decode_gap, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // Once the first letter of a pair leaves, the second follows at once.
    `PFE_ASSERT_NEXT(a_pair_second, clk, rst_n, m_tvalid && m_tready && !m_tlast,
                     m_tvalid && m_tlast)
    // A new pair always starts with its first letter.
    `PFE_ASSERT_IMPL(a_pair_first, clk, rst_n, $rose(m_tvalid), !m_tlast)

endmodule

`default_nettype wire
